>>> sv/tsaw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsaw_pkg;

  // Default texture size limits.
  localparam int TSAW_MAX_PLANE_EXP = 12;
  localparam int TSAW_MAX_DEPTH_EXP = 8;

  // Fixed widths of the configuration port and the address outputs.
  localparam int CFG_EXP_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int ADDR_W      = 32;

  // Configuration register map.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH_EXP        = 2'd0,
    REG_HEIGHT_EXP       = 2'd1,
    REG_DEPTH_EXP        = 2'd2,
    REG_SWIZZLE_ON_WRITE = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> sv/tsaw_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tsaw_cfg #(
  parameter int MAX_PLANE_EXPONENT = 12,
  parameter int MAX_DEPTH_EXPONENT = 8,
  localparam int PW  = MAX_PLANE_EXPONENT,
  localparam int DW  = (MAX_DEPTH_EXPONENT > 0) ? MAX_DEPTH_EXPONENT : 1,
  localparam int PEW = $clog2(MAX_PLANE_EXPONENT + 1),
  localparam int DEW = (MAX_DEPTH_EXPONENT > 0) ? $clog2(MAX_DEPTH_EXPONENT + 1) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tsaw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tsaw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic      [PEW-1:0]                     width_exp_r,
  output logic      [PEW-1:0]                     height_exp_r,
  output logic      [DEW-1:0]                     depth_exp_r,
  output logic      [PW-1:0]                      width_mask_r,
  output logic      [PW-1:0]                      height_mask_r,
  output logic      [DW-1:0]                      depth_mask_r,
  output logic                                    swizzle_on_write_r
);
  import tsaw_pkg::*;

  logic [CFG_EXP_W-1:0] wr_exp;
  logic [PEW-1:0]       plane_exp_nxt;
  logic [DEW-1:0]       depth_exp_nxt;
  logic [PW-1:0]        plane_mask_nxt;
  logic [DW-1:0]        depth_mask_nxt;

  // Exponents saturate at their limits when written.
  function automatic logic [PEW-1:0] clamp_plane(input logic [CFG_EXP_W-1:0] e);
    int v;
    v = int'(e);
    if (v > MAX_PLANE_EXPONENT) v = MAX_PLANE_EXPONENT;
    return PEW'(v);
  endfunction

  function automatic logic [DEW-1:0] clamp_depth(input logic [CFG_EXP_W-1:0] e);
    int v;
    v = int'(e);
    if (v > MAX_DEPTH_EXPONENT) v = MAX_DEPTH_EXPONENT;
    return DEW'(v);
  endfunction

  // Clamped exponent and dimension mask of the word being written.
  always_comb begin
    wr_exp         = cfg_wdata[CFG_EXP_W-1:0];
    plane_exp_nxt  = clamp_plane(wr_exp);
    depth_exp_nxt  = clamp_depth(wr_exp);
    plane_mask_nxt = ~({PW{1'b1}} << plane_exp_nxt);
    depth_mask_nxt = ~({DW{1'b1}} << depth_exp_nxt);
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_exp_r        <= '0;
      height_exp_r       <= '0;
      depth_exp_r        <= '0;
      width_mask_r       <= '0;
      height_mask_r      <= '0;
      depth_mask_r       <= '0;
      swizzle_on_write_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH_EXP: begin
          width_exp_r  <= plane_exp_nxt;
          width_mask_r <= plane_mask_nxt;
        end
        REG_HEIGHT_EXP: begin
          height_exp_r  <= plane_exp_nxt;
          height_mask_r <= plane_mask_nxt;
        end
        REG_DEPTH_EXP: begin
          depth_exp_r  <= depth_exp_nxt;
          depth_mask_r <= depth_mask_nxt;
        end
        REG_SWIZZLE_ON_WRITE: begin
          swizzle_on_write_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/tsaw_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module tsaw_walker #(
  parameter int MAX_PLANE_EXPONENT = 12,
  parameter int MAX_DEPTH_EXPONENT = 8,
  localparam int PW = MAX_PLANE_EXPONENT,
  localparam int DW = (MAX_DEPTH_EXPONENT > 0) ? MAX_DEPTH_EXPONENT : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_restart,
  input  wire logic [PW-1:0] width_mask,
  input  wire logic [PW-1:0] height_mask,
  input  wire logic [DW-1:0] depth_mask,
  input  wire logic          s1_advance,
  output logic               s1_valid_r,
  output logic      [PW-1:0] s1_x_r,
  output logic      [PW-1:0] s1_y_r,
  output logic      [DW-1:0] s1_z_r,
  output logic               s1_last_r
);
  import tsaw_pkg::*;

  logic          accept;
  logic [PW-1:0] x, y;
  logic [DW-1:0] z;
  logic          x_end, y_end, z_end;
  logic [PW-1:0] column_count_r, column_count_nxt;
  logic [PW-1:0] row_count_r, row_count_nxt;
  logic [DW-1:0] slice_count_r, slice_count_nxt;
  logic          s1_valid_nxt;

  // The stage takes a new word when it is empty or its word moves on.
  assign in_ready = !s1_valid_r || s1_advance;
  assign accept   = in_valid && in_ready;

  // Current position, masked to the present texture size.
  always_comb begin
    x     = in_restart ? '0 : (column_count_r & width_mask);
    y     = in_restart ? '0 : (row_count_r & height_mask);
    z     = in_restart ? '0 : (slice_count_r & depth_mask);
    x_end = (x == width_mask);
    y_end = (y == height_mask);
    z_end = (z == depth_mask);
  end

  // Raster advance with wrap after the final texel.
  always_comb begin
    column_count_nxt = x_end ? '0 : x + PW'(1);
    row_count_nxt    = y;
    slice_count_nxt  = z;
    if (x_end) begin
      row_count_nxt = y_end ? '0 : y + PW'(1);
      if (y_end) begin
        slice_count_nxt = z_end ? '0 : z + DW'(1);
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
  end

  // Counters and stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      slice_count_r  <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        column_count_r <= column_count_nxt;
        row_count_r    <= row_count_nxt;
        slice_count_r  <= slice_count_nxt;
      end
    end
  end

  // Position of the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r    <= x;
      s1_y_r    <= y;
      s1_z_r    <= z;
      s1_last_r <= x_end && y_end && z_end;
    end
  end

endmodule

`default_nettype wire

>>> sv/tsaw_addr_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module tsaw_addr_gen #(
  parameter int MAX_PLANE_EXPONENT = 12,
  parameter int MAX_DEPTH_EXPONENT = 8,
  localparam int PW  = MAX_PLANE_EXPONENT,
  localparam int DW  = (MAX_DEPTH_EXPONENT > 0) ? MAX_DEPTH_EXPONENT : 1,
  localparam int PEW = $clog2(MAX_PLANE_EXPONENT + 1),
  localparam int DEW = (MAX_DEPTH_EXPONENT > 0) ? $clog2(MAX_DEPTH_EXPONENT + 1) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [PEW-1:0]                width_exp,
  input  wire logic [PEW-1:0]                height_exp,
  input  wire logic [DEW-1:0]                depth_exp,
  input  wire logic                          swizzle_on_write,
  input  wire logic                          s1_valid,
  input  wire logic [PW-1:0]                 s1_x,
  input  wire logic [PW-1:0]                 s1_y,
  input  wire logic [DW-1:0]                 s1_z,
  input  wire logic                          s1_last,
  output logic                               s1_advance,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tsaw_pkg::ADDR_W-1:0]        out_read_address,
  output logic [tsaw_pkg::ADDR_W-1:0]        out_write_address,
  output logic                               out_last
);
  import tsaw_pkg::*;

  localparam int IW   = 2 * PW + DW;
  localparam int POSW = $clog2(IW);
  localparam int XW   = (IW > ADDR_W) ? IW : ADDR_W;

  logic [POSW-1:0]   pos_x [PW];
  logic [POSW-1:0]   pos_y [PW];
  logic [POSW-1:0]   pos_z [DW];
  logic [PEW:0]      slice_shift;
  logic [IW-1:0]     lin, swz;
  logic [XW-1:0]     lin_ext, swz_ext;
  logic [ADDR_W-1:0] lin_addr, swz_addr;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_read_address_r, out_write_address_r;
  logic              out_last_r;

  // Bit position of every coordinate bit in the swizzled index: the count of
  // bits placed by lower rounds plus those placed earlier in the same round.
  always_comb begin
    for (int r = 0; r < PW; r++) begin
      pos_x[r] = POSW'(r + ((r < int'(height_exp)) ? r : int'(height_exp))
                         + ((r < int'(depth_exp)) ? r : int'(depth_exp)));
      pos_y[r] = POSW'(((r + 1 < int'(width_exp)) ? r + 1 : int'(width_exp)) + r
                         + ((r < int'(depth_exp)) ? r : int'(depth_exp)));
    end
    for (int r = 0; r < DW; r++) begin
      pos_z[r] = POSW'(((r + 1 < int'(width_exp)) ? r + 1 : int'(width_exp))
                         + ((r + 1 < int'(height_exp)) ? r + 1 : int'(height_exp)) + r);
    end
  end

  // Scatter the live coordinate bits to their positions.
  always_comb begin
    swz = '0;
    for (int p = 0; p < IW; p++) begin
      for (int r = 0; r < PW; r++) begin
        if (r < int'(width_exp) && pos_x[r] == POSW'(p) && s1_x[r]) swz[p] = 1'b1;
        if (r < int'(height_exp) && pos_y[r] == POSW'(p) && s1_y[r]) swz[p] = 1'b1;
      end
      for (int r = 0; r < DW; r++) begin
        if (r < int'(depth_exp) && pos_z[r] == POSW'(p) && s1_z[r]) swz[p] = 1'b1;
      end
    end
  end

  // Raster index; the coordinates are masked, so the fields never overlap.
  always_comb begin
    slice_shift = {1'b0, width_exp} + {1'b0, height_exp};
    lin      = IW'(s1_x) | (IW'(s1_y) << width_exp) | (IW'(s1_z) << slice_shift);
    lin_ext  = XW'(lin);
    swz_ext  = XW'(swz);
    lin_addr = lin_ext[ADDR_W-1:0];
    swz_addr = swz_ext[ADDR_W-1:0];
  end

  // Result register handshake.
  assign s1_advance    = !out_valid_r || out_ready;
  assign out_valid_nxt = s1_advance ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word; the direction register picks which index is read.
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_read_address_r  <= swizzle_on_write ? lin_addr : swz_addr;
      out_write_address_r <= swizzle_on_write ? swz_addr : lin_addr;
      out_last_r          <= s1_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_address  = out_read_address_r;
  assign out_write_address = out_write_address_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

>>> sv/texture_swizzle_address_walker.sv
// A word accepted on the input is registered in the position stage and then in
// the result register before it shows on the output.
// Throughput: one word per cycle while the output is not stalled; the position stage
// and the result register each hold one word, and in_ready follows out_ready when both are full.
// Reset (synchronous, active low) clears the configuration registers, the
// position counters and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module texture_swizzle_address_walker #(
  parameter int MAX_PLANE_EXPONENT = tsaw_pkg::TSAW_MAX_PLANE_EXP,
  parameter int MAX_DEPTH_EXPONENT = tsaw_pkg::TSAW_MAX_DEPTH_EXP
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tsaw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tsaw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_restart,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tsaw_pkg::ADDR_W-1:0]             out_read_address,
  output logic [tsaw_pkg::ADDR_W-1:0]             out_write_address,
  output logic                                    out_last
);
  import tsaw_pkg::*;

  localparam int PW  = MAX_PLANE_EXPONENT;
  localparam int DW  = (MAX_DEPTH_EXPONENT > 0) ? MAX_DEPTH_EXPONENT : 1;
  localparam int PEW = $clog2(MAX_PLANE_EXPONENT + 1);
  localparam int DEW = (MAX_DEPTH_EXPONENT > 0) ? $clog2(MAX_DEPTH_EXPONENT + 1) : 1;

  logic [PEW-1:0] width_exp, height_exp;
  logic [DEW-1:0] depth_exp;
  logic [PW-1:0]  width_mask, height_mask;
  logic [DW-1:0]  depth_mask;
  logic           swizzle_on_write;
  logic           s1_advance, s1_valid, s1_last;
  logic [PW-1:0]  s1_x, s1_y;
  logic [DW-1:0]  s1_z;

  // Configuration registers.
  tsaw_cfg #(
    .MAX_PLANE_EXPONENT (MAX_PLANE_EXPONENT),
    .MAX_DEPTH_EXPONENT (MAX_DEPTH_EXPONENT)
  ) u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .width_exp_r        (width_exp),
    .height_exp_r       (height_exp),
    .depth_exp_r        (depth_exp),
    .width_mask_r       (width_mask),
    .height_mask_r      (height_mask),
    .depth_mask_r       (depth_mask),
    .swizzle_on_write_r (swizzle_on_write)
  );

  // Raster counters and position stage.
  tsaw_walker #(
    .MAX_PLANE_EXPONENT (MAX_PLANE_EXPONENT),
    .MAX_DEPTH_EXPONENT (MAX_DEPTH_EXPONENT)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_restart  (in_restart),
    .width_mask  (width_mask),
    .height_mask (height_mask),
    .depth_mask  (depth_mask),
    .s1_advance  (s1_advance),
    .s1_valid_r  (s1_valid),
    .s1_x_r      (s1_x),
    .s1_y_r      (s1_y),
    .s1_z_r      (s1_z),
    .s1_last_r   (s1_last)
  );

  // Index forming and result register.
  tsaw_addr_gen #(
    .MAX_PLANE_EXPONENT (MAX_PLANE_EXPONENT),
    .MAX_DEPTH_EXPONENT (MAX_DEPTH_EXPONENT)
  ) u_addr_gen (
    .clk               (clk),
    .rst_n             (rst_n),
    .width_exp         (width_exp),
    .height_exp        (height_exp),
    .depth_exp         (depth_exp),
    .swizzle_on_write  (swizzle_on_write),
    .s1_valid          (s1_valid),
    .s1_x              (s1_x),
    .s1_y              (s1_y),
    .s1_z              (s1_z),
    .s1_last           (s1_last),
    .s1_advance        (s1_advance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_address  (out_read_address),
    .out_write_address (out_write_address),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

>>> sv/tsaw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tsaw_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [tsaw_pkg::ADDR_W-1:0]        out_read_address,
  input wire logic [tsaw_pkg::ADDR_W-1:0]        out_write_address,
  input wire logic                               out_last
);
  import tsaw_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_address)
      && $stable(out_write_address) && $stable(out_last))
    else $error("stalled result word changed");

  // With the output empty, the pipeline can always take a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // The origin is the only texel whose raster and swizzled indices are zero.
  a_origin_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_address == '0 |-> out_write_address == '0)
    else $error("address pair disagrees on the origin texel");

endmodule

bind texture_swizzle_address_walker tsaw_checker u_tsaw_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tsaw_pkg::*;

  // One address word as it leaves the block.
  typedef struct packed {
    logic [ADDR_W-1:0] rd;
    logic [ADDR_W-1:0] wr;
    logic              last;
  } texel_addr_t;

  // Tracks the walk position and configuration, and holds the address words still owed.
  class walk_scoreboard;
    logic [CFG_EXP_W-1:0] width_exp;
    logic [CFG_EXP_W-1:0] height_exp;
    logic [CFG_EXP_W-1:0] depth_exp;
    logic                 swz_on_write;
    int unsigned          col;
    int unsigned          row;
    int unsigned          slice;
    texel_addr_t          owed[$];
    int                   ticks;
    int                   frame_ends;
    int                   mismatches;

    function new();
      width_exp    = '0;
      height_exp   = '0;
      depth_exp    = '0;
      swz_on_write = 1'b0;
      col          = 0;
      row          = 0;
      slice        = 0;
      ticks        = 0;
      frame_ends   = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WIDTH_EXP:        width_exp    = val;
        REG_HEIGHT_EXP:       height_exp   = val;
        REG_DEPTH_EXP:        depth_exp    = val;
        REG_SWIZZLE_ON_WRITE: swz_on_write = val[0];
        default: ;
      endcase
    endfunction

    // Forms the linear and Morton indices of the current texel, then steps the walk.
    function void note_tick(bit restart);
      int unsigned     ew, eh, ed, mw, mh, md, x, y, z, pos, r;
      longint unsigned lin, swz;
      texel_addr_t     want;
      ew = (width_exp > TSAW_MAX_PLANE_EXP) ? TSAW_MAX_PLANE_EXP : width_exp;
      eh = (height_exp > TSAW_MAX_PLANE_EXP) ? TSAW_MAX_PLANE_EXP : height_exp;
      ed = (depth_exp > TSAW_MAX_DEPTH_EXP) ? TSAW_MAX_DEPTH_EXP : depth_exp;
      mw = 32'((64'd1 << ew) - 64'd1);
      mh = 32'((64'd1 << eh) - 64'd1);
      md = 32'((64'd1 << ed) - 64'd1);
      if (restart) begin
        col   = 0;
        row   = 0;
        slice = 0;
      end
      // Counters are masked so a size change in mid-frame resumes inside the new size.
      x = col & mw;
      y = row & mh;
      z = slice & md;
      lin = 64'(x) + (64'(y) << ew) + (64'(z) << (ew + eh));
      // Interleave x, y, z bits from the bottom; a used-up dimension drops out.
      swz = 0;
      pos = 0;
      for (r = 0; r < 32; r++) begin
        if (r < ew) begin
          swz[pos] = x[r];
          pos++;
        end
        if (r < eh) begin
          swz[pos] = y[r];
          pos++;
        end
        if (r < ed) begin
          swz[pos] = z[r];
          pos++;
        end
      end
      want.last = (x == mw) && (y == mh) && (z == md);
      if (swz_on_write) begin
        want.rd = lin[ADDR_W-1:0];
        want.wr = swz[ADDR_W-1:0];
      end else begin
        want.rd = swz[ADDR_W-1:0];
        want.wr = lin[ADDR_W-1:0];
      end
      owed.push_back(want);
      ticks++;
      // Raster advance with wrap after the final texel.
      if (x == mw) begin
        x = 0;
        if (y == mh) begin
          y = 0;
          z = (z == md) ? 0 : z + 1;
        end else begin
          y++;
        end
      end else begin
        x++;
      end
      col   = x;
      row   = y;
      slice = z;
    endfunction

    function void check_word(texel_addr_t got);
      texel_addr_t want;
      if (owed.size() == 0) begin
        $error("address word arrived with none owed");
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (got.last) frame_ends++;
      if (got.rd !== want.rd) begin
        $error("read_address: expected %h, got %h", want.rd, got.rd);
        mismatches++;
      end
      if (got.wr !== want.wr) begin
        $error("write_address: expected %h, got %h", want.wr, got.wr);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 500;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ADDR_W-1:0]      out_read_address;
  logic [ADDR_W-1:0]      out_write_address;
  logic                   out_last;

  walk_scoreboard sb = new();
  bit             quiet_tail = 1'b0;
  bit             hold_req = 1'b0;
  int             settings_seen = 0;
  int             idle_cycles = 0;

  texture_swizzle_address_walker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_address  (out_read_address),
    .out_write_address (out_write_address),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One register write; the caller lowers the write enable when done.
  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] d, logic sow);
    put_reg(REG_WIDTH_EXP, w);
    put_reg(REG_HEIGHT_EXP, h);
    put_reg(REG_DEPTH_EXP, d);
    put_reg(REG_SWIZZLE_ON_WRITE, {3'b000, sow});
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // Offers one input word, with an occasional idle burst before it.
  task automatic send_tick(bit restart);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(restart);
  endtask

  // Drops valid and waits until every owed address word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: checks each accepted word and stalls in random bursts,
  // plus one long hold-off that backs the block up into its input.
  initial begin
    int          stall_left;
    int          hold_left;
    bit          hold_done;
    texel_addr_t got;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.rd   = out_read_address;
        got.wr   = out_write_address;
        got.last = out_last;
        sb.check_word(got);
      end
      if (!hold_done && hold_req) begin
        hold_left = 48;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed frames, then random register settings.
  initial begin
    int       k;
    int       n;
    int       mode;
    int       random_ticks;
    cfg_reg_t pick;
    random_ticks = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a single-texel texture, every word is address 0 with last set.
    for (k = 0; k < 3; k++) send_tick(k == 1);
    settle();

    // A 2x2x2 cube with a restart partway through, before the walk reaches its wrap.
    apply_config(4'd1, 4'd1, 4'd1, 1'b0);
    for (k = 0; k < 10; k++) send_tick(k == 6);
    settle();

    // Exponents above their limits saturate; the walk resumes inside the new size.
    apply_config(4'd15, 4'd14, 4'd13, 1'b1);
    for (k = 0; k < 4; k++) send_tick(k == 2);
    settle();

    // Depth only: width and height take no part in the interleave.
    apply_config(4'd0, 4'd0, 4'd2, 1'b0);
    for (k = 0; k < 5; k++) send_tick(1'b0);
    settle();

    // Largest legal sizes exactly.
    apply_config(4'd12, 4'd12, 4'd8, 1'b1);
    for (k = 0; k < 3; k++) send_tick(k == 0);
    settle();

    // The receiver holds off while words keep coming, so the block backs up.
    apply_config(4'd2, 4'd1, 4'd0, 1'b0);
    hold_req = 1'b1;
    for (k = 0; k < 20; k++) send_tick(1'b0);
    settle();

    // Random settings: mostly small textures so frames wrap often,
    // some single-register changes in mid-frame, some arbitrary sizes.
    while (random_ticks < RANDOM_TICKS) begin
      quiet_tail = (random_ticks >= RANDOM_TICKS - 80);
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        apply_config(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                     CFG_DATA_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
      end else if (mode < 8) begin
        pick = cfg_reg_t'(CFG_INDEX_W'($urandom_range(0, 3)));
        put_reg(pick, CFG_DATA_W'($urandom_range(0, 15)));
        cfg_we <= 1'b0;
        settings_seen++;
      end else begin
        apply_config(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)),
                     CFG_DATA_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      n = $urandom_range(8, 40);
      for (k = 0; k < n; k++) send_tick($urandom_range(0, 15) == 0);
      settle();
      random_ticks += n;
    end

    repeat (10) @(posedge clk);
    $display("Walked %0d texel ticks across %0d register settings.", sb.ticks, settings_seen);
    $display("Saw %0d frame ends, including saturated and mid-frame size changes.",
             sb.frame_ends);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
